/* hw/rtl/fluid_safety_alarm_sequencer_top_assert.svh */
// Assertion macros used by the checker of the fluid safety alarm sequencer.
`ifndef FLUID_SAFETY_ALARM_SEQUENCER_TOP_ASSERT_SVH
`define FLUID_SAFETY_ALARM_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* hw/rtl/fsas_pkg.sv */
// Types, constants and register map of the fluid safety alarm sequencer.
`default_nettype none
package fsas_pkg;

  localparam int unsigned TempW   = 12;
  localparam int unsigned PresW   = 16;
  localparam int unsigned MsW     = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ViewW   = 2;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned ApbDataW = 32;

  // Register indexes (byte address / 4).
  localparam logic [2:0] RegTempWarn = 3'd0;
  localparam logic [2:0] RegTempKill = 3'd1;
  localparam logic [2:0] RegPresWarn = 3'd2;
  localparam logic [2:0] RegDebounce = 3'd3;
  localparam logic [2:0] RegRotate   = 3'd4;

  // Register reset values; temperatures are signed tenths of a degree.
  localparam logic signed [TempW-1:0] TempWarnRst = 12'sd250;
  localparam logic signed [TempW-1:0] TempKillRst = 12'sd350;
  localparam logic [PresW-1:0]        PresWarnRst = 16'd200;
  localparam logic [MsW-1:0]          DebounceRst = 16'd50;
  localparam logic [MsW-1:0]          RotateRst   = 16'd2000;

  // View codes.
  localparam logic [ViewW-1:0] ViewTemp  = 2'd0;
  localparam logic [ViewW-1:0] ViewPres  = 2'd1;
  localparam logic [ViewW-1:0] ViewAir   = 2'd2;
  localparam logic [ViewW-1:0] ViewNone  = 2'd3;

  // Halt causes.
  localparam logic CauseTemp = 1'b0;
  localparam logic CauseAir  = 1'b1;

  typedef struct packed {
    logic signed [TempW-1:0] temp_warn_limit;
    logic signed [TempW-1:0] temp_kill_limit;
    logic [PresW-1:0]        pressure_warn_limit;
    logic [MsW-1:0]          debounce_time;
    logic [MsW-1:0]          rotate_time;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]        now_ms;
    logic                    button_level;
    logic                    air_in_line;
    logic [PresW-1:0]        pressure_value;
    logic signed [TempW-1:0] temperature;
  } sample_t;

  typedef struct packed {
    logic [ViewW-1:0] view_selected;
    logic             normal_repaint;
    logic             alert_shown;
    logic             alert_repaint;
    logic             halt_cause;
    logic             halt_entered;
    logic             kill_led;
    logic             pressure_led;
    logic             temp_led;
  } result_t;

  typedef struct packed {
    logic             halted;
    logic             halt_reason;
    logic             prev_button;
    logic [TimeW-1:0] last_press_time;
    logic [ViewW-1:0] view;
    logic [ViewW-1:0] drawn_view;
    logic             was_alerting;
    logic             alert_index;
    logic [TimeW-1:0] last_rotate_time;
  } state_t;

  localparam state_t StateRst = '{
    halted:           1'b0,
    halt_reason:      CauseTemp,
    prev_button:      1'b1,
    last_press_time:  '0,
    view:             ViewAir,
    drawn_view:       ViewNone,
    was_alerting:     1'b0,
    alert_index:      1'b0,
    last_rotate_time: '0
  };

endpackage
`default_nettype wire

/* hw/rtl/fsas_cfg_regs.sv */
// Configuration register file with its APB-style access port.
`default_nettype none
module fsas_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fsas_pkg::AddrW-1:0]    paddr,
  input  wire logic [fsas_pkg::ApbDataW-1:0] pwdata,
  output logic      [fsas_pkg::ApbDataW-1:0] prdata,
  output logic                               pready,
  output fsas_pkg::cfg_t                     cfg_o
);
  import fsas_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AddrW-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        RegTempWarn: cfg_d.temp_warn_limit     = pwdata[TempW-1:0];
        RegTempKill: cfg_d.temp_kill_limit     = pwdata[TempW-1:0];
        RegPresWarn: cfg_d.pressure_warn_limit = pwdata[PresW-1:0];
        RegDebounce: cfg_d.debounce_time       = pwdata[MsW-1:0];
        RegRotate:   cfg_d.rotate_time         = pwdata[MsW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_warn_limit     <= TempWarnRst;
      cfg_q.temp_kill_limit     <= TempKillRst;
      cfg_q.pressure_warn_limit <= PresWarnRst;
      cfg_q.debounce_time       <= DebounceRst;
      cfg_q.rotate_time         <= RotateRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Signed limits read back sign-extended.
  always_comb begin
    case (reg_idx)
      RegTempWarn: prdata = {{(ApbDataW-TempW){cfg_q.temp_warn_limit[TempW-1]}},
                             cfg_q.temp_warn_limit};
      RegTempKill: prdata = {{(ApbDataW-TempW){cfg_q.temp_kill_limit[TempW-1]}},
                             cfg_q.temp_kill_limit};
      RegPresWarn: prdata = {{(ApbDataW-PresW){1'b0}}, cfg_q.pressure_warn_limit};
      RegDebounce: prdata = {{(ApbDataW-MsW){1'b0}}, cfg_q.debounce_time};
      RegRotate:   prdata = {{(ApbDataW-MsW){1'b0}}, cfg_q.rotate_time};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* hw/rtl/fsas_step.sv */
// Next-state and result logic for one monitor sample.
`default_nettype none
module fsas_step (
  input  wire fsas_pkg::cfg_t    cfg_i,
  input  wire fsas_pkg::state_t  state_i,
  input  wire fsas_pkg::sample_t sample_i,
  output fsas_pkg::state_t       state_o,
  output fsas_pkg::result_t      result_o
);
  import fsas_pkg::*;

  logic             over_kill;
  logic             entered;
  logic             warm_hit;
  logic             pres_hit;
  logic             any_alert;
  logic             both_alert;
  logic [TimeW-1:0] since_press;
  logic [TimeW-1:0] since_rotate;
  logic             press;
  logic             first;
  logic             rotate;
  logic             idx_n;
  logic [ViewW-1:0] view_n;

  assign over_kill = $signed(sample_i.temperature) > $signed(cfg_i.temp_kill_limit);
  assign entered   = !state_i.halted && (over_kill || sample_i.air_in_line);
  assign warm_hit  = $signed(sample_i.temperature) > $signed(cfg_i.temp_warn_limit);
  assign pres_hit  = sample_i.pressure_value > cfg_i.pressure_warn_limit;
  assign any_alert  = warm_hit || pres_hit;
  assign both_alert = warm_hit && pres_hit;

  assign since_press  = sample_i.now_ms - state_i.last_press_time;
  assign since_rotate = sample_i.now_ms - state_i.last_rotate_time;
  assign press  = !sample_i.button_level && state_i.prev_button &&
                  (since_press > {{(TimeW-MsW){1'b0}}, cfg_i.debounce_time});
  assign first  = !state_i.was_alerting;
  assign rotate = since_rotate >= {{(TimeW-MsW){1'b0}}, cfg_i.rotate_time};

  // With one alert the index always settles at zero; with two it toggles on rotation.
  always_comb begin
    if (!both_alert || first) begin
      idx_n = 1'b0;
    end else if (rotate) begin
      idx_n = !state_i.alert_index;
    end else begin
      idx_n = state_i.alert_index;
    end
  end

  always_comb begin
    if (!press) begin
      view_n = state_i.view;
    end else if (state_i.view >= ViewAir) begin
      view_n = ViewTemp;
    end else begin
      view_n = state_i.view + 2'd1;
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (state_i.halted || entered) begin
      state_o.halted = 1'b1;
      if (entered) begin
        state_o.halt_reason = over_kill ? CauseTemp : CauseAir;
      end
      result_o.kill_led      = 1'b1;
      result_o.halt_entered  = entered;
      result_o.halt_cause    = state_o.halt_reason;
      result_o.view_selected = state_i.view;
    end else begin
      result_o.temp_led      = warm_hit;
      result_o.pressure_led  = pres_hit;
      result_o.halt_cause    = state_i.halt_reason;
      result_o.view_selected = view_n;
      state_o.view        = view_n;
      state_o.prev_button = sample_i.button_level;
      if (press) begin
        state_o.last_press_time = sample_i.now_ms;
      end
      if (any_alert) begin
        state_o.alert_index  = idx_n;
        state_o.was_alerting = 1'b1;
        result_o.alert_shown = both_alert ? idx_n : pres_hit;
        if (first || rotate) begin
          state_o.last_rotate_time = sample_i.now_ms;
          state_o.drawn_view       = ViewNone;
          result_o.alert_repaint   = 1'b1;
        end
      end else if (state_i.was_alerting || (view_n != state_i.drawn_view)) begin
        result_o.normal_repaint = 1'b1;
        state_o.drawn_view      = view_n;
        state_o.was_alerting    = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fluid_safety_alarm_sequencer_top.sv */
// Top level of the fluid safety alarm sequencer: sample stream in, alarm result stream out.
`default_nettype none
// The block takes one monitor sample per transaction and returns exactly one result
// transaction for it, in order. A sample is held in an input register; the alarm logic
// between that register and the result register evaluates it combinationally and updates
// the sequencer state at the same edge as the result is loaded. The sustained rate is
// one sample per clock cycle while the result stream is not stalled. A sample's result
// is loaded from the input register into the result register once that one is empty
// or being drained. The registers are decoupled, so a new sample can be taken into an
// empty input register while a finished result still waits to be read.
// Overtemperature (checked first) or air in the line latches a halt that only reset
// clears. Configuration registers are written through the APB-style port at byte
// addresses 0, 4, 8, 12 and 16 (warning and halt temperature limits in signed tenths
// of a degree, pressure warning limit, debounce time and rotation time in ms); write
// them only while no sample is in flight.
module fluid_safety_alarm_sequencer_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Sample stream.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // From bit 0: temperature[11:0], pressure_value[27:12], air_in_line[28],
  // button_level[29], now_ms[61:30], zero fill[63:62].
  input  wire logic [fsas_pkg::InDataW-1:0]  s_axis_tdata,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // From bit 0: temp_led, pressure_led, kill_led, halt_entered, halt_cause,
  // alert_repaint, alert_shown, normal_repaint, view_selected[9:8], zero fill[15:10].
  output logic      [fsas_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fsas_pkg::AddrW-1:0]    paddr,
  input  wire logic [fsas_pkg::ApbDataW-1:0] pwdata,
  output logic      [fsas_pkg::ApbDataW-1:0] prdata,
  output logic                               pready
);
  import fsas_pkg::*;

  localparam int unsigned SampleW = $bits(sample_t);
  localparam int unsigned ResultW = $bits(result_t);

  cfg_t    cfg;
  state_t  state_q, state_d;
  sample_t in_data_q;
  logic    in_vld_q, in_vld_d;
  result_t out_data_q;
  result_t step_res;
  logic    out_vld_q, out_vld_d;
  logic    load;
  logic    take;

  fsas_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fsas_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .sample_i (in_data_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // The held sample moves on when the result register is empty or being drained.
  assign load          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || load;
  assign take          = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = take || (in_vld_q && !load);
  assign out_vld_d = load || (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= StateRst;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (load) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      in_data_q <= s_axis_tdata[SampleW-1:0];
    end
    if (load) begin
      out_data_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-ResultW){1'b0}}, out_data_q};

endmodule
`default_nettype wire

/* hw/rtl/fsas_checker.sv */
// Port-level assertions for the fluid safety alarm sequencer, bound to its top level.
`default_nettype none
`include "fluid_safety_alarm_sequencer_top_assert.svh"
module fsas_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [fsas_pkg::OutDataW-1:0] m_axis_tdata
);
  import fsas_pkg::*;

  result_t res;
  logic    out_xfer;
  logic    kill_seen_q, kill_seen_d;

  assign res      = m_axis_tdata[$bits(result_t)-1:0];
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign kill_seen_d = kill_seen_q || (out_xfer && res.kill_led);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kill_seen_q <= 1'b0;
    end else begin
      kill_seen_q <= kill_seen_d;
    end
  end

  // A halt is latched: once a kill result is delivered, every later result shows it
  // and none claims to have entered the halt again.
  `FSAS_ASSERT_NOW(a_halt_latched, clk_i, rst_ni, m_axis_tvalid && kill_seen_q,
                   res.kill_led && !res.halt_entered)

  // While halted the warning LEDs and repaint flags stay dark.
  `FSAS_ASSERT_NOW(a_halt_quiet, clk_i, rst_ni, m_axis_tvalid && res.kill_led,
                   !res.temp_led && !res.pressure_led && !res.alert_repaint &&
                   !res.normal_repaint && !res.alert_shown)

  // The view never reaches the unused code, and the halt entry implies the kill LED.
  `FSAS_ASSERT_NOW(a_view_and_entry, clk_i, rst_ni, m_axis_tvalid,
                   (res.view_selected != ViewNone) &&
                   (!res.halt_entered || res.kill_led))

  // A stalled result holds its value.
  `FSAS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind fluid_safety_alarm_sequencer_top fsas_checker u_fsas_checker (.*);
`default_nettype wire

/* bench/fluid_safety_alarm_sequencer_top_tb.sv */
// Self-checking testbench for the fluid safety alarm sequencer top level.
`default_nettype none

module fluid_safety_alarm_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsas_pkg::*;

  // A result is loaded into the result register after its sample is accepted; the settle
  // time adds idle margin on top of that.
  localparam int unsigned SettleCycles = 8;
  // Slowest correct run is roughly 1700 samples, with one side idling or stalling heavily
  // in some phases, plus register writes. The limit is many times that.
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned PhaseSamples = 200;
  localparam int unsigned PreHaltCount = 10;
  localparam int unsigned HaltedCount  = 30;
  // The phase whose time base sits just below the 32-bit rollover.
  localparam int unsigned WrapPhase    = 4;

  localparam int ResW = $bits(result_t);
  localparam int PadW = InDataW - $bits(sample_t);

  // Indexes past the end of the register map; writes there must change nothing.
  localparam logic [2:0] RegSpareLo = 3'd5;
  localparam logic [2:0] RegSpareHi = 3'd7;

  // Codes of the alert that is on display.
  localparam logic ShowTemp = 1'b0;
  localparam logic ShowPres = 1'b1;

  // Idle and stall percentages of the four traffic modes: none, sender idling,
  // receiver stalling, and both sides idling lightly.
  localparam int unsigned SendIdle[4]  = '{0, 84, 0, 22};
  localparam int unsigned RecvStall[4] = '{0, 0, 84, 22};
  localparam int unsigned LightMode    = 3;

  localparam result_t NoResult = '0;

  typedef enum int {HaltByTemp, HaltByAir, HaltByBoth} halt_mode_e;

  // One row of the directed table; rows with pinned set carry a hand-written result.
  typedef struct {
    sample_t smp;
    bit      pinned;
    result_t want;
  } vector_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [AddrW-1:0]      paddr;
  logic [ApbDataW-1:0]   pwdata;
  logic [ApbDataW-1:0]   prdata;
  logic                  pready;

  // Shadow copy of the configuration registers.
  logic signed [TempW-1:0] lim_warn_temp;
  logic signed [TempW-1:0] lim_temp_kill;
  logic [PresW-1:0]        lim_warn_pres;
  logic [MsW-1:0]          dly_debounce;
  logic [MsW-1:0]          dly_rotate;

  // Shadow copy of the sequencer state.
  logic             pr_halted;
  logic             pr_cause;
  logic             pr_button;
  logic [TimeW-1:0] pr_press_ms;
  logic [ViewW-1:0] pr_view;
  logic [ViewW-1:0] pr_drawn;
  logic             pr_alerting;
  logic             pr_alert_idx;
  logic [TimeW-1:0] pr_rotate_ms;

  // Results that have been predicted but not yet seen on the result stream.
  result_t alarm_expect_q[$];
  vector_t directed_q[$];
  result_t head_want;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;

  // Sample generator state: a running millisecond clock and the button pin level.
  logic [TimeW-1:0] cur_ms;
  logic             btn_level;

  fluid_safety_alarm_sequencer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 2 ns clock period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[fluid_safety_alarm_sequencer_top] ERROR");
      $finish;
    end
  end

  // Computes the result of one sample and advances the shadow state, the way the
  // sequencer does when it accepts the sample.
  function automatic result_t predict_alarm(input sample_t s);
    result_t          r;
    logic             entered;
    logic             warm_hit;
    logic             pres_hit;
    logic [1:0]       active;
    logic             first_alert;
    logic             rotate_due;
    logic [TimeW-1:0] since_press;
    logic [TimeW-1:0] since_rotate;
    r = '0;
    entered = 1'b0;
    // Overtemperature wins over air when both show up on the same sample.
    if (!pr_halted) begin
      if ($signed(s.temperature) > lim_temp_kill) begin
        pr_halted = 1'b1;
        pr_cause  = CauseTemp;
        entered   = 1'b1;
      end else if (s.air_in_line) begin
        pr_halted = 1'b1;
        pr_cause  = CauseAir;
        entered   = 1'b1;
      end
    end
    // Halted: only the kill LED, and nothing else moves, not even the button.
    if (pr_halted) begin
      r.kill_led      = 1'b1;
      r.halt_entered  = entered;
      r.halt_cause    = pr_cause;
      r.view_selected = pr_view;
      return r;
    end

    warm_hit = $signed(s.temperature) > lim_warn_temp;
    pres_hit = s.pressure_value > lim_warn_pres;
    active   = {1'b0, warm_hit} + {1'b0, pres_hit};
    r.temp_led     = warm_hit;
    r.pressure_led = pres_hit;
    r.halt_cause   = pr_cause;

    // Debounced falling edge steps the view around its three positions.
    since_press = s.now_ms - pr_press_ms;
    if (!s.button_level && pr_button && since_press > {16'd0, dly_debounce}) begin
      pr_view     = (pr_view >= ViewAir) ? ViewTemp : pr_view + 2'd1;
      pr_press_ms = s.now_ms;
    end
    pr_button = s.button_level;

    if (active != 2'd0) begin
      since_rotate = s.now_ms - pr_rotate_ms;
      first_alert  = !pr_alerting;
      rotate_due   = since_rotate >= {16'd0, dly_rotate};
      if (first_alert) begin
        pr_alert_idx = 1'b0;
        pr_rotate_ms = s.now_ms;
      end else if (rotate_due) begin
        pr_alert_idx = (active == 2'd2) ? ~pr_alert_idx : 1'b0;
        pr_rotate_ms = s.now_ms;
      end
      // A shrunken alert list leaves only index zero.
      if (active == 2'd1) pr_alert_idx = 1'b0;
      // Index zero is the temperature alert only if that one is active.
      r.alert_shown = (pr_alert_idx || !warm_hit) ? ShowPres : ShowTemp;
      if (first_alert || rotate_due) begin
        r.alert_repaint = 1'b1;
        pr_drawn = ViewNone;
      end
      pr_alerting = 1'b1;
    end else if (pr_alerting || pr_view != pr_drawn) begin
      r.normal_repaint = 1'b1;
      pr_drawn    = pr_view;
      pr_alerting = 1'b0;
    end
    r.view_selected = pr_view;
    return r;
  endfunction

  // One bit per output field that differs, fill bits on top.
  function automatic logic [9:0] field_diffs(input result_t want,
                                             input logic [OutDataW-1:0] raw);
    result_t got;
    got = raw[ResW-1:0];
    return {raw[OutDataW-1:ResW] != '0,
            got.view_selected  !== want.view_selected,
            got.normal_repaint !== want.normal_repaint,
            got.alert_shown    !== want.alert_shown,
            got.alert_repaint  !== want.alert_repaint,
            got.halt_cause     !== want.halt_cause,
            got.halt_entered   !== want.halt_entered,
            got.kill_led       !== want.kill_led,
            got.pressure_led   !== want.pressure_led,
            got.temp_led       !== want.temp_led};
  endfunction

  function automatic string show_result(input result_t r);
    string leds;
    leds = $sformatf("temp_led=%0d pres_led=%0d kill=%0d entered=%0d cause=%0d",
                     r.temp_led, r.pressure_led, r.kill_led, r.halt_entered, r.halt_cause);
    return {leds, $sformatf(" alert_repaint=%0d shown=%0d normal_repaint=%0d view=%0d",
                            r.alert_repaint, r.alert_shown, r.normal_repaint,
                            r.view_selected)};
  endfunction

  task automatic report_fault(input string what, input result_t want,
                              input logic [OutDataW-1:0] raw);
    fault_count++;
    if (fault_count <= MaxReports) begin
      $display("%0t: %s, differing fields %b", $time, what, field_diffs(want, raw));
      $display("  expected %s", show_result(want));
      $display("  actual   %s (raw %h)", show_result(raw[ResW-1:0]), raw);
    end
  endtask

  // Result side: every accepted result transaction is checked against the oldest
  // prediction, and the ready line is re-rolled every cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (alarm_expect_q.size() == 0) begin
        report_fault("result with no sample outstanding", NoResult, m_axis_tdata);
      end else begin
        head_want = alarm_expect_q.pop_front();
        if (field_diffs(head_want, m_axis_tdata) != '0) begin
          report_fault("result mismatch", head_want, m_axis_tdata);
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic void add_vector(input int temp, input int pres, input bit btn,
                                     input logic [TimeW-1:0] now, input bit pinned,
                                     input result_t want);
    vector_t v;
    v.smp.temperature    = temp[TempW-1:0];
    v.smp.pressure_value = pres[PresW-1:0];
    v.smp.air_in_line    = 1'b0;
    v.smp.button_level   = btn;
    v.smp.now_ms         = now;
    v.pinned             = pinned;
    v.want               = want;
    directed_q.push_back(v);
  endfunction

  // Random sample with a live shape: temperature and pressure hover around their
  // warning limits, the button toggles, and time mostly creeps forward with the
  // odd jump. Temperature stays at or below the halt limit and air stays off, so
  // the sequencer never latches a halt here.
  function automatic sample_t make_sample();
    sample_t     s;
    int          temp_v;
    int          pres_v;
    int          kill_v;
    int          warn_v;
    int unsigned roll;
    kill_v = lim_temp_kill;
    warn_v = lim_warn_temp;
    roll = $urandom_range(0, 99);
    if (roll < 10) temp_v = int'($urandom_range(0, 4095)) - 2048;
    else temp_v = warn_v + int'($urandom_range(0, 40)) - 20;
    if (temp_v > kill_v) temp_v = kill_v;
    if (temp_v < -2048) temp_v = -2048;

    roll = $urandom_range(0, 99);
    if (roll < 10) pres_v = int'($urandom_range(0, 65535));
    else if (roll < 15) pres_v = 65535;
    else if (roll < 20) pres_v = 0;
    else pres_v = int'(lim_warn_pres) + int'($urandom_range(0, 40)) - 20;
    if (pres_v < 0) pres_v = 0;
    if (pres_v > 65535) pres_v = 65535;

    if ($urandom_range(0, 99) < 30) btn_level = ~btn_level;

    roll = $urandom_range(0, 99);
    if (roll < 5) cur_ms = $urandom;
    else if (roll < 10) cur_ms = cur_ms + $urandom_range(0, 70000);
    else if (roll >= 15) cur_ms = cur_ms + $urandom_range(0, 400);

    s.temperature    = temp_v[TempW-1:0];
    s.pressure_value = pres_v[PresW-1:0];
    s.air_in_line    = 1'b0;
    s.button_level   = btn_level;
    s.now_ms         = cur_ms;
    return s;
  endfunction

  // Offers one sample after a random idle stretch and waits for the handshake.
  // The prediction is made at the acceptance edge; a pinned row replaces it with
  // its hand-written result but still advances the shadow state.
  task automatic send_sample(input sample_t s, input bit pinned, input result_t want);
    result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PadW{1'b0}}, s};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_alarm(s);
    alarm_expect_q.push_back(pinned ? want : pred);
  endtask

  // Stops the sample stream until every result is back, then lets the pipeline
  // settle. Register writes after the first sample only happen after this.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (alarm_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready. Bits above the
  // register's width carry random junk, which the register must drop.
  task automatic write_register(input logic [2:0] index, input logic [31:0] value);
    logic [31:0] keep;
    logic [31:0] data;
    keep = (index == RegTempWarn || index == RegTempKill) ? 32'h0000_0FFF : 32'h0000_FFFF;
    data = ($urandom & ~keep) | (value & keep);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      RegTempWarn: lim_warn_temp = data[TempW-1:0];
      RegTempKill: lim_temp_kill = data[TempW-1:0];
      RegPresWarn: lim_warn_pres = data[PresW-1:0];
      RegDebounce: dly_debounce  = data[MsW-1:0];
      RegRotate:   dly_rotate    = data[MsW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin
    int          warn_v;
    int          kill_v;
    int          pres_v;
    int          deb_v;
    int          rot_v;
    int          temp_v;
    halt_mode_e  halt_mode;
    sample_t     smp;
    logic [31:0] noise;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_ni        = 1'b0;
    send_idle_pct = SendIdle[LightMode];
    stall_pct     = RecvStall[LightMode];
    cur_ms        = '0;
    btn_level     = 1'b1;

    lim_warn_temp = TempWarnRst;
    lim_temp_kill = TempKillRst;
    lim_warn_pres = PresWarnRst;
    dly_debounce  = DebounceRst;
    dly_rotate    = RotateRst;
    pr_halted     = 1'b0;
    pr_cause      = CauseTemp;
    pr_button     = 1'b1;
    pr_press_ms   = '0;
    pr_view       = ViewAir;
    pr_drawn      = ViewNone;
    pr_alerting   = 1'b0;
    pr_alert_idx  = 1'b0;
    pr_rotate_ms  = '0;

    // Directed table, run with the reset limits (warn 25.0 C, halt 35.0 C,
    // pressure 200, debounce 50 ms, rotation 2000 ms).
    // Nothing drawn yet after reset, so the air status view is painted first.
    add_vector(0, 0, 1'b1, 32'd0, 1'b1,
               result_t'{normal_repaint: 1'b1, view_selected: ViewAir, default: '0});
    // Coldest reading, view already drawn: everything quiet.
    add_vector(-2048, 0, 1'b1, 32'd10, 1'b1, result_t'{view_selected: ViewAir, default: '0});
    // Exactly at the halt limit: warns but does not halt; alert screen entry.
    add_vector(350, 200, 1'b1, 32'd20, 1'b1,
               result_t'{temp_led: 1'b1, alert_repaint: 1'b1, alert_shown: ShowTemp,
                         view_selected: ViewAir, default: '0});
    // Both alerts, then a rotation exactly at the rotation time.
    add_vector(251, 201, 1'b1, 32'd30, 1'b0, NoResult);
    add_vector(251, 65535, 1'b1, 32'd2020, 1'b0, NoResult);
    // Temperature alert drops while the pressure one is shown: index is clamped.
    add_vector(250, 65535, 1'b1, 32'd2030, 1'b0, NoResult);
    // Alerts clear: the normal view must be redrawn.
    add_vector(0, 0, 1'b1, 32'd2040, 1'b0, NoResult);
    // Button presses: accepted, bounced (exactly the debounce time), accepted,
    // and the view wrapping from air status back to temperature.
    add_vector(0, 0, 1'b0, 32'd2050, 1'b0, NoResult);
    add_vector(0, 0, 1'b1, 32'd2060, 1'b0, NoResult);
    add_vector(0, 0, 1'b0, 32'd2100, 1'b0, NoResult);
    add_vector(0, 0, 1'b1, 32'd2100, 1'b0, NoResult);
    add_vector(0, 0, 1'b0, 32'd2101, 1'b0, NoResult);
    add_vector(0, 0, 1'b1, 32'd2200, 1'b0, NoResult);
    add_vector(0, 0, 1'b0, 32'd2300, 1'b0, NoResult);
    add_vector(0, 0, 1'b1, 32'd2300, 1'b0, NoResult);
    add_vector(0, 0, 1'b0, 32'd2400, 1'b0, NoResult);
    // Time at its top value and then wrapped past zero.
    add_vector(-1, 65535, 1'b1, 32'hFFFF_FFFF, 1'b0, NoResult);
    add_vector(0, 0, 1'b0, 32'd5, 1'b0, NoResult);
    add_vector(350, 0, 1'b1, 32'd6, 1'b0, NoResult);
    // Exactly at both warning limits: neither warns.
    add_vector(250, 200, 1'b1, 32'd7, 1'b0, NoResult);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Writes past the register map must leave every limit untouched; the first
    // pinned rows below would show it.
    for (int i = RegSpareLo; i <= RegSpareHi; i++) write_register(3'(i), $urandom);

    foreach (directed_q[i]) begin
      send_sample(directed_q[i].smp, directed_q[i].pinned, directed_q[i].want);
    end

    // Random phases. Each one waits for the pipeline to empty, loads a new set of
    // limits and a traffic mode, and streams a batch of samples.
    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      case (p)
        0: begin
          warn_v = TempWarnRst;
          kill_v = TempKillRst;
          pres_v = PresWarnRst;
          deb_v  = DebounceRst;
          rot_v  = RotateRst;
        end
        1: begin
          // Every reading above its lowest value warns, and alerts rotate on every alerting sample.
          warn_v = -2048;
          kill_v = 2047;
          pres_v = 0;
          deb_v  = 0;
          rot_v  = 0;
        end
        2: begin
          // Nothing can warn; presses need a long quiet time.
          warn_v = 2047;
          kill_v = 2047;
          pres_v = 65535;
          deb_v  = 65535;
          rot_v  = 65535;
        end
        default: begin
          warn_v = int'($urandom_range(0, 800)) - 300;
          kill_v = ($urandom_range(0, 3) == 0) ? 2047 : warn_v + int'($urandom_range(0, 400));
          if (kill_v > 2047) kill_v = 2047;
          pres_v = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                               : int'($urandom_range(0, 1000));
          deb_v  = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 300));
          rot_v  = (p == 3) ? 65535 : int'($urandom_range(0, 3000));
        end
      endcase
      write_register(RegTempWarn, warn_v);
      write_register(RegTempKill, kill_v);
      write_register(RegPresWarn, pres_v);
      write_register(RegDebounce, deb_v);
      write_register(RegRotate, rot_v);
      send_idle_pct = SendIdle[p % 4];
      stall_pct     = RecvStall[p % 4];
      if (p == WrapPhase) cur_ms = 32'hFFFF_F000;
      for (int n = 0; n < PhaseSamples; n++) send_sample(make_sample(), 1'b0, NoResult);
    end

    // Final phase: the halt latches until reset, and reset happens only once, so
    // the halt comes last. The cause is picked at random per run, including the
    // case where overtemperature and air arrive together.
    drain_results();
    send_idle_pct = SendIdle[LightMode];
    stall_pct     = RecvStall[LightMode];
    kill_v = ($urandom_range(0, 9) < 3) ? -2048 : int'($urandom_range(0, 4094)) - 2048;
    write_register(RegTempKill, kill_v);
    repeat (PreHaltCount) send_sample(make_sample(), 1'b0, NoResult);

    halt_mode = halt_mode_e'($urandom_range(0, 2));
    smp = make_sample();
    if (halt_mode != HaltByAir) begin
      temp_v = ($urandom_range(0, 1) == 1) ? 2047
                                           : kill_v + 1 + int'($urandom_range(0, 2046 - kill_v));
      smp.temperature = temp_v[TempW-1:0];
    end
    if (halt_mode != HaltByTemp) smp.air_in_line = 1'b1;
    send_sample(smp, 1'b0, NoResult);

    // While halted every field is noise and must be ignored.
    repeat (HaltedCount) begin
      noise = $urandom;
      smp.temperature    = noise[11:0];
      smp.pressure_value = noise[27:12];
      smp.air_in_line    = noise[28];
      smp.button_level   = noise[29];
      smp.now_ms         = $urandom;
      send_sample(smp, 1'b0, NoResult);
    end

    drain_results();
    if (fault_count == 0 && alarm_expect_q.size() == 0) begin
      $display("[fluid_safety_alarm_sequencer_top] OK");
    end else begin
      $display("[fluid_safety_alarm_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
